### sv/fdc_pkg.sv
// Shared types, constants and coefficient functions for the FIR decimator core.
package fdc_pkg;

  localparam int SAMPLE_WIDTH        = 16;
  localparam int ACC_W               = 38;
  localparam int DECIMATION_DEF      = 8;
  localparam int COEF_FRAC_BITS_DEF  = 15;
  localparam logic [63:0] PI_Q28     = 64'd843314857;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
  } result_t;

  // Restoring long division, build-time only.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series sine in Q28, truncating at every step.
  function automatic logic [63:0] sin_q28(input logic [63:0] x);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = signed'(x);
    term = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 28;
      term = (term * x) >> 28;
      term = udiv(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return (sum < 0) ? 64'd0 : unsigned'(sum);
  endfunction

  // Tap k of a D-tap table in unsigned Q(f).
  function automatic logic [63:0] tap_coef(input int d, input int f, input int k);
    logic [63:0] dd;
    logic [63:0] one;
    logic [63:0] i;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] den;
    dd  = 64'(d);
    one = 64'd1 << f;
    if (k >= d - 1) begin
      return udiv(one + (dd >> 1), dd);
    end
    i   = dd - 64'd1 - 64'(k);
    m   = (i < dd - i) ? i : dd - i;
    x   = udiv(PI_Q28 * m + (dd >> 1), dd);
    s   = sin_q28(x);
    den = PI_Q28 * i;
    return udiv(s * one + (den >> 1), den);
  endfunction

endpackage

### sv/fdc_round_sat.sv
// Round-half-up from Q(FRAC_BITS) and saturate an accumulator to sample width.
module fdc_round_sat #(
  parameter int FRAC_BITS = fdc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic signed [fdc_pkg::ACC_W-1:0]        acc,
  output logic signed [fdc_pkg::SAMPLE_WIDTH-1:0] q
);

  localparam int EXT_W = fdc_pkg::ACC_W + 1;
  localparam logic signed [EXT_W-1:0] HALF = EXT_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [EXT_W-1:0] MAXV =
    EXT_W'((64'd1 << (fdc_pkg::SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [EXT_W-1:0] MINV = -MAXV - EXT_W'(1);

  logic signed [EXT_W-1:0] biased;
  logic signed [EXT_W-1:0] shifted;

  always_comb begin
    biased  = {acc[fdc_pkg::ACC_W-1], acc} + HALF;
    shifted = biased >>> FRAC_BITS;
    if (shifted > MAXV) begin
      q = MAXV[fdc_pkg::SAMPLE_WIDTH-1:0];
    end else if (shifted < MINV) begin
      q = MINV[fdc_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      q = shifted[fdc_pkg::SAMPLE_WIDTH-1:0];
    end
  end

endmodule

### sv/block_fir_decimator_core.sv
// Top level of the complex integrate-and-dump FIR decimator.
//
// Input channel (sample, sample_valid, sample_stall) takes one complex I/Q
// item per cycle while sample_stall is low. Each item is weighted by the
// next entry of a fixed real tap table and summed; after DECIMATION items
// the rounded, saturated sum leaves on the result channel (result,
// result_valid, result_stall) and the sum restarts from zero. Blocks do
// not overlap. The last item of a block passes the input register, the
// multiplier register, the accumulator result register and the output
// register before its result appears. Throughput: one item per cycle
// while not stalled, one result per DECIMATION items.
// Reset clears the tap counter, the accumulators and all valid flags.
// While result_stall holds a result, items keep flowing into the
// accumulator; the input stalls only when the next finished block has
// nowhere to go, after which the pipeline drains as the output frees up.
module block_fir_decimator_core #(
  parameter int DECIMATION     = fdc_pkg::DECIMATION_DEF,
  parameter int COEF_FRAC_BITS = fdc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  fdc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output fdc_pkg::result_t result
);

  localparam int SW     = fdc_pkg::SAMPLE_WIDTH;
  localparam int ACC_W  = fdc_pkg::ACC_W;
  localparam int TAP_W  = $clog2(DECIMATION);
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SW + COEF_W + 1;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(DECIMATION - 1);

  logic [COEF_W-1:0] coef_rom [DECIMATION];

  for (genvar k = 0; k < DECIMATION; k++) begin : g_coef
    localparam logic [COEF_W-1:0] COEF =
      COEF_W'(fdc_pkg::tap_coef(DECIMATION, COEF_FRAC_BITS, k));
    assign coef_rom[k] = COEF;
  end

  logic [TAP_W-1:0] tap;
  logic             tap_last;

  logic                     smp_valid;
  logic signed [SW-1:0]     smp_re;
  logic signed [SW-1:0]     smp_im;
  logic [COEF_W-1:0]        smp_coef;
  logic                     smp_last;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic                     prod_last;

  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [ACC_W-1:0]  acc_re_next;
  logic signed [ACC_W-1:0]  acc_im_next;

  logic                     raw_valid;
  logic signed [ACC_W-1:0]  raw_re;
  logic signed [ACC_W-1:0]  raw_im;

  logic signed [SW-1:0]     rnd_re;
  logic signed [SW-1:0]     rnd_im;

  logic out_free;
  logic raw_free;
  logic prod_take;
  logic prod_free;
  logic smp_take;
  logic smp_free;
  logic accept;

  always_comb begin
    out_free     = !result_valid || !result_stall;
    raw_free     = !raw_valid || out_free;
    prod_take    = prod_valid && (!prod_last || raw_free);
    prod_free    = !prod_valid || prod_take;
    smp_take     = smp_valid && prod_free;
    smp_free     = !smp_valid || smp_take;
    sample_stall = !smp_free;
    accept       = sample_valid && smp_free;
    tap_last     = (tap == TAP_LAST);
    acc_re_next  = acc_re + ACC_W'(prod_re);
    acc_im_next  = acc_im + ACC_W'(prod_im);
  end

  fdc_round_sat #(.FRAC_BITS(COEF_FRAC_BITS)) u_round_re (.acc(raw_re), .q(rnd_re));
  fdc_round_sat #(.FRAC_BITS(COEF_FRAC_BITS)) u_round_im (.acc(raw_im), .q(rnd_im));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tap          <= '0;
      smp_valid    <= 1'b0;
      prod_valid   <= 1'b0;
      raw_valid    <= 1'b0;
      result_valid <= 1'b0;
      acc_re       <= '0;
      acc_im       <= '0;
    end else begin
      if (accept) begin
        tap <= tap_last ? '0 : tap + TAP_W'(1);
      end
      if (accept) begin
        smp_valid <= 1'b1;
      end else if (smp_take) begin
        smp_valid <= 1'b0;
      end
      if (smp_take) begin
        prod_valid <= 1'b1;
      end else if (prod_take) begin
        prod_valid <= 1'b0;
      end
      if (prod_take) begin
        if (prod_last) begin
          acc_re <= '0;
          acc_im <= '0;
        end else begin
          acc_re <= acc_re_next;
          acc_im <= acc_im_next;
        end
      end
      if (prod_take && prod_last) begin
        raw_valid <= 1'b1;
      end else if (raw_valid && out_free) begin
        raw_valid <= 1'b0;
      end
      if (raw_valid && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_re   <= sample.sample_re;
      smp_im   <= sample.sample_im;
      smp_coef <= coef_rom[tap];
      smp_last <= tap_last;
    end
    if (smp_take) begin
      prod_re   <= smp_re * $signed({1'b0, smp_coef});
      prod_im   <= smp_im * $signed({1'b0, smp_coef});
      prod_last <= smp_last;
    end
    if (prod_take && prod_last) begin
      raw_re <= acc_re_next;
      raw_im <= acc_im_next;
    end
    if (raw_valid && out_free) begin
      result.out_re <= rnd_re;
      result.out_im <= rnd_im;
    end
  end

endmodule
